// ===== src/hba_pkg.sv =====
`timescale 1ns / 1ps

package hba_pkg;

  // fixed field widths
  localparam int unsigned OFF_W  = 16;
  localparam int unsigned SIZE_W = 17;  // rounded size can reach 65536
  localparam int unsigned TOP_W  = 17;
  localparam int unsigned USE_W  = 7;

  // request types
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  // placement policies
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DECIDE,
    OP_SCAN,
    OP_ALLOC,
    OP_SHUP,
    OP_WRNEW,
    OP_RDPREV,
    OP_RDNEXT,
    OP_MERGE,
    OP_SHDN
  } op_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic is_alloc;
    logic size_zero;
    logic rel_null;
    logic scan_done;
    logic pick_vld;
    logic do_split;
    logic shift_done;
  } dp_sts_t;

  // one block table entry
  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] pay;
    logic             free;
  } entry_t;

endpackage

// ===== src/hba_ctrl.sv =====
`timescale 1ns / 1ps

module hba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  hba_pkg::dp_sts_t sts_i,
  output hba_pkg::op_e     op_o,
  output logic             busy_o,
  output logic             done_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_ALLOC  = 4'd3;
  localparam logic [3:0] S_SHUP   = 4'd4;
  localparam logic [3:0] S_WRNEW  = 4'd5;
  localparam logic [3:0] S_RDPREV = 4'd6;
  localparam logic [3:0] S_RDNEXT = 4'd7;
  localparam logic [3:0] S_MERGE  = 4'd8;
  localparam logic [3:0] S_SHDN   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_o    = hba_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_o    = hba_pkg::OP_LATCH;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        op_o = hba_pkg::OP_DECIDE;
        if (sts_i.is_alloc) begin
          state_d = sts_i.size_zero ? S_DONE : S_SCAN;
        end else begin
          state_d = sts_i.rel_null ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        op_o = hba_pkg::OP_SCAN;
        if (sts_i.scan_done) begin
          if (sts_i.is_alloc) begin
            state_d = S_ALLOC;
          end else begin
            state_d = sts_i.pick_vld ? S_RDPREV : S_DONE;
          end
        end
      end
      S_ALLOC: begin
        op_o    = hba_pkg::OP_ALLOC;
        state_d = sts_i.do_split ? S_SHUP : S_DONE;
      end
      S_SHUP: begin
        op_o = hba_pkg::OP_SHUP;
        if (sts_i.shift_done) state_d = S_WRNEW;
      end
      S_WRNEW: begin
        op_o    = hba_pkg::OP_WRNEW;
        state_d = S_DONE;
      end
      S_RDPREV: begin
        op_o    = hba_pkg::OP_RDPREV;
        state_d = S_RDNEXT;
      end
      S_RDNEXT: begin
        op_o    = hba_pkg::OP_RDNEXT;
        state_d = S_MERGE;
      end
      S_MERGE: begin
        op_o    = hba_pkg::OP_MERGE;
        state_d = S_SHDN;
      end
      S_SHDN: begin
        op_o = hba_pkg::OP_SHDN;
        if (sts_i.shift_done) state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ===== src/hba_dp.sv =====
`timescale 1ns / 1ps

module hba_dp #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hba_pkg::op_e                 op_i,
  output hba_pkg::dp_sts_t             sts_o,
  input  logic                         req_type_i,
  input  logic [hba_pkg::OFF_W-1:0]    req_size_i,
  input  logic [hba_pkg::OFF_W-1:0]    release_offset_i,
  input  logic                         fit_mode_we_i,
  input  logic [1:0]                   fit_mode_i,
  output logic [1:0]                   status_o,
  output logic [hba_pkg::OFF_W-1:0]    payload_offset_o,
  output logic [hba_pkg::OFF_W-1:0]    granted_size_o,
  output logic                         reused_o,
  output logic                         split_done_o,
  output logic                         grew_o,
  output logic [1:0]                   merges_o,
  output logic [hba_pkg::USE_W-1:0]    blocks_in_use_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned OW    = hba_pkg::OFF_W;
  localparam int unsigned SW    = hba_pkg::SIZE_W;
  localparam int unsigned TW    = hba_pkg::TOP_W;

  localparam logic [OW-1:0]    H16     = OW'(HEADER_BYTES);
  localparam logic [SW-1:0]    H17     = SW'(HEADER_BYTES);
  localparam logic [TW:0]      H18     = (TW+1)'(HEADER_BYTES);
  localparam logic [TW:0]      HEAP18  = (TW+1)'(HEAP_BYTES);
  localparam logic [OW-1:0]    MIN_SPL = OW'(HEADER_BYTES + 4);
  localparam logic [CNT_W-1:0] MAXB    = CNT_W'(MAX_BLOCKS);

  // block table
  hba_pkg::entry_t mem [MAX_BLOCKS];
  hba_pkg::entry_t rdata_q, wdata;
  logic [IDX_W-1:0] raddr, waddr;
  logic             we;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  logic             type_q, type_d;
  logic [SW-1:0]    size_q, size_d;
  logic [OW-1:0]    rel_q, rel_d;
  logic [1:0]       fit_q;
  logic [CNT_W-1:0] total_q, total_d;
  logic [TW-1:0]    top_q, top_d;
  logic [IDX_W-1:0] rover_q, rover_d;
  logic             rover_vld_q, rover_vld_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             found_q, found_d;
  logic             pick_vld_q, pick_vld_d;
  logic [IDX_W-1:0] pick_idx_q, pick_idx_d;
  logic [OW-1:0]    pick_start_q, pick_start_d;
  logic [OW-1:0]    pick_pay_q, pick_pay_d;
  logic [OW-1:0]    prev_start_q, prev_start_d;
  logic [OW-1:0]    prev_pay_q, prev_pay_d;
  logic             prev_free_q, prev_free_d;
  logic [IDX_W-1:0] sh_src_q, sh_src_d;
  logic [CNT_W-1:0] sh_left_q, sh_left_d;
  logic [1:0]       rmv_q, rmv_d;
  logic [1:0]       status_q, status_d;
  logic [OW-1:0]    poff_q, poff_d;
  logic [OW-1:0]    gsize_q, gsize_d;
  logic             reused_q, reused_d;
  logic             split_q, split_d;
  logic             grew_q, grew_d;
  logic [1:0]       merges_q, merges_d;

  logic             is_alloc, is_first, match, better, take;
  logic [OW-1:0]    rest;
  logic             do_split, grow_ok, scan_done, shift_done;
  logic             pf, nf;
  logic [IDX_W-1:0] s_idx;
  logic [1:0]       r_cnt;
  logic [TW:0]      msum;

  assign is_alloc = (type_q == hba_pkg::REQ_ALLOC);
  assign is_first = !is_alloc || (fit_q == hba_pkg::FIT_FIRST) || (fit_q == hba_pkg::FIT_NEXT);
  assign match    = is_alloc ? (rdata_q.free && ({1'b0, rdata_q.pay} >= size_q))
                             : (!rdata_q.free && (({1'b0, rdata_q.start} + H17) == {1'b0, rel_q}));
  assign better   = !pick_vld_q || is_first
                 || ((fit_q == hba_pkg::FIT_BEST) && (rdata_q.pay < pick_pay_q))
                 || ((fit_q == hba_pkg::FIT_WORST) && (rdata_q.pay > pick_pay_q));
  assign take     = rd_vld_q && !found_q && match && better;

  assign rest     = pick_pay_q - size_q[OW-1:0];
  assign do_split = pick_vld_q && (rest >= MIN_SPL) && (total_q < MAXB);
  assign grow_ok  = (total_q < MAXB)
                 && (({1'b0, top_q} + H18 + {1'b0, size_q}) <= HEAP18);
  assign scan_done  = found_q || ((cnt_q == total_q) && !rd_vld_q);
  assign shift_done = (sh_left_q == '0) && !rd_vld_q;

  // merge terms: survivor index and number of removed entries
  assign pf    = (pick_idx_q != '0) && prev_free_q;
  assign nf    = ((CNT_W'(pick_idx_q) + CNT_W'(1)) < total_q) && rdata_q.free;
  assign s_idx = pf ? (pick_idx_q - IDX_W'(1)) : pick_idx_q;
  assign r_cnt = {1'b0, pf} + {1'b0, nf};
  assign msum  = (TW+1)'(pick_pay_q)
               + (pf ? ((TW+1)'(prev_pay_q) + H18) : '0)
               + (nf ? ((TW+1)'(rdata_q.pay) + H18) : '0);

  always_comb begin
    type_d       = type_q;
    size_d       = size_q;
    rel_d        = rel_q;
    total_d      = total_q;
    top_d        = top_q;
    rover_d      = rover_q;
    rover_vld_d  = rover_vld_q;
    cnt_d        = cnt_q;
    cur_d        = cur_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    found_d      = found_q;
    pick_vld_d   = pick_vld_q;
    pick_idx_d   = pick_idx_q;
    pick_start_d = pick_start_q;
    pick_pay_d   = pick_pay_q;
    prev_start_d = prev_start_q;
    prev_pay_d   = prev_pay_q;
    prev_free_d  = prev_free_q;
    sh_src_d     = sh_src_q;
    sh_left_d    = sh_left_q;
    rmv_d        = rmv_q;
    status_d     = status_q;
    poff_d       = poff_q;
    gsize_d      = gsize_q;
    reused_d     = reused_q;
    split_d      = split_q;
    grew_d       = grew_q;
    merges_d     = merges_q;
    we           = 1'b0;
    waddr        = cur_q;
    wdata        = rdata_q;
    raddr        = cur_q;
    unique case (op_i)
      hba_pkg::OP_NONE: begin
      end
      hba_pkg::OP_LATCH: begin
        type_d   = req_type_i;
        size_d   = ({1'b0, req_size_i} + SW'(3)) & ~SW'(3);
        rel_d    = release_offset_i;
        status_d = hba_pkg::ST_OK;
        poff_d   = '0;
        gsize_d  = '0;
        reused_d = 1'b0;
        split_d  = 1'b0;
        grew_d   = 1'b0;
        merges_d = '0;
      end
      hba_pkg::OP_DECIDE: begin
        if (is_alloc && (size_q == '0)) status_d = hba_pkg::ST_ZERO;
        cnt_d      = '0;
        found_d    = 1'b0;
        pick_vld_d = 1'b0;
        if (is_alloc && (fit_q == hba_pkg::FIT_NEXT) && rover_vld_q
            && ((CNT_W'(rover_q) + CNT_W'(1)) < total_q)) begin
          cur_d = rover_q + IDX_W'(1);
        end else begin
          cur_d = '0;
        end
      end
      hba_pkg::OP_SCAN: begin
        if (take) begin
          pick_vld_d   = 1'b1;
          pick_idx_d   = rd_idx_q;
          pick_start_d = rdata_q.start;
          pick_pay_d   = rdata_q.pay;
          found_d      = is_first;
          if (is_alloc && (fit_q == hba_pkg::FIT_NEXT)) begin
            rover_d     = rd_idx_q;
            rover_vld_d = 1'b1;
          end
        end
        if ((cnt_q != total_q) && !found_q) begin
          raddr    = cur_q;
          rd_vld_d = 1'b1;
          rd_idx_d = cur_q;
          cnt_d    = cnt_q + CNT_W'(1);
          cur_d    = ((CNT_W'(cur_q) + CNT_W'(1)) >= total_q) ? '0 : (cur_q + IDX_W'(1));
        end
        if (scan_done && !is_alloc && !pick_vld_q) status_d = hba_pkg::ST_BAD;
      end
      hba_pkg::OP_ALLOC: begin
        if (pick_vld_q) begin
          we          = 1'b1;
          waddr       = pick_idx_q;
          wdata.start = pick_start_q;
          wdata.pay   = do_split ? size_q[OW-1:0] : pick_pay_q;
          wdata.free  = 1'b0;
          reused_d    = 1'b1;
          split_d     = do_split;
          poff_d      = pick_start_q + H16;
          gsize_d     = do_split ? size_q[OW-1:0] : pick_pay_q;
          sh_src_d    = IDX_W'(total_q - CNT_W'(1));
          sh_left_d   = total_q - CNT_W'(1) - CNT_W'(pick_idx_q);
        end else if (grow_ok) begin
          we          = 1'b1;
          waddr       = IDX_W'(total_q);
          wdata.start = top_q[OW-1:0];
          wdata.pay   = size_q[OW-1:0];
          wdata.free  = 1'b0;
          total_d     = total_q + CNT_W'(1);
          top_d       = top_q + H17 + size_q;
          grew_d      = 1'b1;
          poff_d      = top_q[OW-1:0] + H16;
          gsize_d     = size_q[OW-1:0];
        end else begin
          status_d = hba_pkg::ST_NOSPACE;
        end
      end
      hba_pkg::OP_SHUP: begin
        if (sh_left_q != '0) begin
          raddr     = sh_src_q;
          rd_vld_d  = 1'b1;
          rd_idx_d  = sh_src_q;
          sh_src_d  = sh_src_q - IDX_W'(1);
          sh_left_d = sh_left_q - CNT_W'(1);
        end
        if (rd_vld_q) begin
          we    = 1'b1;
          waddr = rd_idx_q + IDX_W'(1);
          wdata = rdata_q;
        end
      end
      hba_pkg::OP_WRNEW: begin
        we          = 1'b1;
        waddr       = pick_idx_q + IDX_W'(1);
        wdata.start = pick_start_q + H16 + size_q[OW-1:0];
        wdata.pay   = rest - H16;
        wdata.free  = 1'b1;
        total_d     = total_q + CNT_W'(1);
        if (rover_vld_q && (rover_q > pick_idx_q)) rover_d = rover_q + IDX_W'(1);
      end
      hba_pkg::OP_RDPREV: begin
        raddr = pick_idx_q - IDX_W'(1);
      end
      hba_pkg::OP_RDNEXT: begin
        raddr        = pick_idx_q + IDX_W'(1);
        prev_start_d = rdata_q.start;
        prev_pay_d   = rdata_q.pay;
        prev_free_d  = rdata_q.free;
      end
      hba_pkg::OP_MERGE: begin
        we          = 1'b1;
        waddr       = s_idx;
        wdata.start = pf ? prev_start_q : pick_start_q;
        wdata.pay   = msum[OW-1:0];
        wdata.free  = 1'b1;
        merges_d    = r_cnt;
        total_d     = total_q - CNT_W'(r_cnt);
        rmv_d       = r_cnt;
        sh_src_d    = IDX_W'(CNT_W'(s_idx) + CNT_W'(r_cnt) + CNT_W'(1));
        sh_left_d   = (r_cnt == '0) ? '0
                    : (total_q - CNT_W'(1) - CNT_W'(s_idx) - CNT_W'(r_cnt));
        if (rover_vld_q) begin
          if (CNT_W'(rover_q) > (CNT_W'(s_idx) + CNT_W'(r_cnt))) begin
            rover_d = rover_q - IDX_W'(r_cnt);
          end else if (rover_q > s_idx) begin
            rover_d = s_idx;
          end
        end
      end
      hba_pkg::OP_SHDN: begin
        if (sh_left_q != '0) begin
          raddr     = sh_src_q;
          rd_vld_d  = 1'b1;
          rd_idx_d  = sh_src_q;
          sh_src_d  = sh_src_q + IDX_W'(1);
          sh_left_d = sh_left_q - CNT_W'(1);
        end
        if (rd_vld_q) begin
          we    = 1'b1;
          waddr = rd_idx_q - IDX_W'(rmv_q);
          wdata = rdata_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q       <= hba_pkg::FIT_FIRST;
      total_q     <= '0;
      top_q       <= '0;
      rover_q     <= '0;
      rover_vld_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      pick_vld_q  <= 1'b0;
      cnt_q       <= '0;
      sh_left_q   <= '0;
      status_q    <= hba_pkg::ST_OK;
      type_q      <= hba_pkg::REQ_ALLOC;
    end else begin
      if (fit_mode_we_i) fit_q <= fit_mode_i;
      total_q     <= total_d;
      top_q       <= top_d;
      rover_q     <= rover_d;
      rover_vld_q <= rover_vld_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      pick_vld_q  <= pick_vld_d;
      cnt_q       <= cnt_d;
      sh_left_q   <= sh_left_d;
      status_q    <= status_d;
      type_q      <= type_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q       <= size_d;
    rel_q        <= rel_d;
    cur_q        <= cur_d;
    rd_idx_q     <= rd_idx_d;
    pick_idx_q   <= pick_idx_d;
    pick_start_q <= pick_start_d;
    pick_pay_q   <= pick_pay_d;
    prev_start_q <= prev_start_d;
    prev_pay_q   <= prev_pay_d;
    prev_free_q  <= prev_free_d;
    sh_src_q     <= sh_src_d;
    rmv_q        <= rmv_d;
    poff_q       <= poff_d;
    gsize_q      <= gsize_d;
    reused_q     <= reused_d;
    split_q      <= split_d;
    grew_q       <= grew_d;
    merges_q     <= merges_d;
  end

  assign sts_o.is_alloc   = is_alloc;
  assign sts_o.size_zero  = (size_q == '0);
  assign sts_o.rel_null   = (rel_q == '0);
  assign sts_o.scan_done  = scan_done;
  assign sts_o.pick_vld   = pick_vld_q;
  assign sts_o.do_split   = do_split;
  assign sts_o.shift_done = shift_done;

  assign status_o         = status_q;
  assign payload_offset_o = poff_q;
  assign granted_size_o   = gsize_q;
  assign reused_o         = reused_q;
  assign split_done_o     = split_q;
  assign grew_o           = grew_q;
  assign merges_o         = merges_q;
  assign blocks_in_use_o  = hba_pkg::USE_W'(total_q);

endmodule

// ===== src/heap_block_allocator.sv =====
`timescale 1ns / 1ps

// channel   | handshake                   | payload
// ----------+-----------------------------+--------------------------------------------
// request   | start_i, taken when !busy_o | req_type_i, req_size_i, release_offset_i
// result    | done_o, one-cycle strobe    | status_o, payload_offset_o, granted_size_o,
//           |                             | reused_o, split_done_o, grew_o, merges_o,
//           |                             | blocks_in_use_o
// config    | fit_mode_we_i               | fit_mode_i
//
// the table scan of a request reads one entry per cycle through the single read port
// of the block table, and a split or a merge then also moves table entries
// reset clears the table count, heap top, next-fit mark and fit mode; table contents
// need no clearing since entries past the count are never used
// results cannot be stalled: done_o is high for one cycle, then a new request is taken

module heap_block_allocator #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [15:0] req_size_i,
  input  logic [15:0] release_offset_i,
  // configuration
  input  logic        fit_mode_we_i,
  input  logic [1:0]  fit_mode_i,
  // result
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] payload_offset_o,
  output logic [15:0] granted_size_o,
  output logic        reused_o,
  output logic        split_done_o,
  output logic        grew_o,
  output logic [1:0]  merges_o,
  output logic [6:0]  blocks_in_use_o
);

  // operation from the sequencer, status back from the table datapath
  hba_pkg::op_e     op;
  hba_pkg::dp_sts_t sts;

  // sequencer: latch, scan, then allocate/grow or merge, moving entries as needed
  hba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .op_o    (op),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // block table, scan and pick logic, heap top, next-fit mark, result registers
  hba_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .sts_o            (sts),
    .req_type_i       (req_type_i),
    .req_size_i       (req_size_i),
    .release_offset_i (release_offset_i),
    .fit_mode_we_i    (fit_mode_we_i),
    .fit_mode_i       (fit_mode_i),
    .status_o         (status_o),
    .payload_offset_o (payload_offset_o),
    .granted_size_o   (granted_size_o),
    .reused_o         (reused_o),
    .split_done_o     (split_done_o),
    .grew_o           (grew_o),
    .merges_o         (merges_o),
    .blocks_in_use_o  (blocks_in_use_o)
  );

endmodule

// ===== src/hba_checker.sv =====
`timescale 1ns / 1ps

module hba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        req_type_i,
  input logic [15:0] req_size_i,
  input logic [15:0] release_offset_i,
  input logic        fit_mode_we_i,
  input logic [1:0]  fit_mode_i,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [15:0] payload_offset_o,
  input logic [15:0] granted_size_o,
  input logic        reused_o,
  input logic        split_done_o,
  input logic        grew_o,
  input logic [1:0]  merges_o,
  input logic [6:0]  blocks_in_use_o
);

  // a result only appears while a request is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe while idle");

  // a taken request keeps the block busy
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("request not taken");

  // one result per request
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  // failed requests carry no grant
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != hba_pkg::ST_OK)) |->
      ((payload_offset_o == 16'd0) && (granted_size_o == 16'd0) && !reused_o && !grew_o
       && !split_done_o)) else $error("grant fields set on failure");

  // a grant comes either from reuse or from growth, never both, and never with merges
  a_reuse_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && reused_o) |-> (!grew_o && (merges_o == 2'd0)))
    else $error("reuse and growth in one result");

endmodule

bind heap_block_allocator hba_checker u_hba_checker (.*);
